>>> sv/gsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Shared sizes, command and status codes, and memory request types.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int unsigned SLOTS    = 1024;
  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_STALE     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  typedef struct packed {
    logic [CNT_W-1:0] limit;
  } gsa_cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [GEN_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } gsa_gen_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } gsa_q_req_t;

endpackage

>>> sv/gsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gsa_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator configuration port
// APB register holding the slot count and deriving the active slot limit.
// ----------------------------------------------------------------------------
module gsa_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output gsa_pkg::gsa_cfg_t cfg_o
);
  import gsa_pkg::*;

  logic [CNT_W-1:0] slot_count_q;
  logic [CNT_W-1:0] slot_count_d;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);

  always_comb begin
    slot_count_d = slot_count_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      slot_count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOTS_CNT;
    end else begin
      slot_count_q <= slot_count_d;
    end
  end

  assign prdata      = reg_hit ? {{(32-CNT_W){1'b0}}, slot_count_q} : 32'd0;
  assign cfg_o.limit = (slot_count_q > SLOTS_CNT) ? SLOTS_CNT : slot_count_q;

endmodule

>>> sv/gsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator controller
// Sequencer that clears the generation memory, reads, modifies and writes
// back the generation and free-queue memories, and holds the result.
// ----------------------------------------------------------------------------
module gsa_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gsa_pkg::gsa_cfg_t              cfg_i,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [gsa_pkg::CMD_W-1:0]      s_cmd_i,
  input  logic [gsa_pkg::IDX_W-1:0]      s_idx_i,
  input  logic [gsa_pkg::GEN_W-1:0]      s_gen_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [gsa_pkg::STATUS_W-1:0]   m_status_o,
  output logic [gsa_pkg::IDX_W-1:0]      m_idx_o,
  output logic [gsa_pkg::GEN_W-1:0]      m_gen_o,
  output gsa_pkg::gsa_gen_req_t          gen_req_o,
  input  logic [gsa_pkg::GEN_W-1:0]      gen_rdata_i,
  output gsa_pkg::gsa_q_req_t            q_req_o,
  input  logic [gsa_pkg::IDX_W-1:0]      q_rdata_i
);
  import gsa_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_QREAD = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  logic [CNT_W-1:0]    fresh_q, fresh_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [IDX_W-1:0]    idx_q;
  logic [GEN_W-1:0]    hgen_q;
  logic                m_valid_q, m_valid_d;
  logic [STATUS_W-1:0] m_status_q;
  logic [IDX_W-1:0]    m_idx_q;
  logic [GEN_W-1:0]    m_gen_q;

  logic                accept;
  logic                commit;
  logic                fresh_ok;
  logic                q_nonempty;
  logic                idx_ok;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_idx;
  logic [GEN_W-1:0]    res_gen;
  logic                do_fresh, do_pop, do_write, do_push;
  logic [GEN_W-1:0]    gen_inc;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign commit     = (state_q == ST_EXEC) && (!m_valid_q || m_tready_i);
  assign fresh_ok   = fresh_q < cfg_i.limit;
  assign q_nonempty = (count_q != '0);
  assign idx_ok     = {1'b0, idx_q} < cfg_i.limit;
  assign gen_inc    = gen_rdata_i + GEN_W'(1);

  always_comb begin
    res_status = STATUS_OK;
    res_idx    = '0;
    res_gen    = '0;
    do_fresh   = 1'b0;
    do_pop     = 1'b0;
    do_write   = 1'b0;
    do_push    = 1'b0;
    case (cmd_q)
      CMD_ALLOC: begin
        if (fresh_ok) begin
          res_idx  = fresh_q[IDX_W-1:0];
          res_gen  = gen_rdata_i;
          do_fresh = 1'b1;
        end else if (q_nonempty) begin
          res_idx = q_rdata_i;
          res_gen = gen_rdata_i;
          do_pop  = 1'b1;
        end else begin
          res_status = STATUS_EXHAUSTED;
        end
      end
      CMD_RELEASE, CMD_LOOKUP: begin
        if (!idx_ok) begin
          res_status = STATUS_RANGE;
        end else if (gen_rdata_i != hgen_q) begin
          res_status = STATUS_STALE;
          res_idx    = idx_q;
          res_gen    = gen_rdata_i;
        end else if (cmd_q == CMD_RELEASE) begin
          res_idx  = idx_q;
          res_gen  = gen_inc;
          do_write = 1'b1;
          do_push  = (count_q < SLOTS_CNT);
        end else begin
          res_idx = idx_q;
          res_gen = gen_rdata_i;
        end
      end
      default: begin
        res_status = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    fresh_d   = fresh_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    m_valid_d = m_valid_q && !m_tready_i;

    gen_req_o = '0;
    q_req_o   = '0;

    case (state_q)
      ST_CLEAR: begin
        gen_req_o.we    = 1'b1;
        gen_req_o.waddr = clr_q;
        clr_d           = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          gen_req_o.re    = 1'b1;
          q_req_o.re      = 1'b1;
          q_req_o.raddr   = head_q;
          if (s_cmd_i == CMD_ALLOC && fresh_ok) begin
            gen_req_o.raddr = fresh_q[IDX_W-1:0];
          end else begin
            gen_req_o.raddr = s_idx_i;
          end
          if (s_cmd_i == CMD_ALLOC && !fresh_ok && q_nonempty) begin
            state_d = ST_QREAD;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_QREAD: begin
        gen_req_o.re    = 1'b1;
        gen_req_o.raddr = q_rdata_i;
        state_d         = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
          if (do_fresh) begin
            fresh_d = fresh_q + CNT_W'(1);
          end
          if (do_pop) begin
            head_d  = head_q + IDX_W'(1);
            count_d = count_q - CNT_W'(1);
          end
          if (do_write) begin
            gen_req_o.we    = 1'b1;
            gen_req_o.waddr = idx_q;
            gen_req_o.wdata = gen_inc;
          end
          if (do_push) begin
            q_req_o.we    = 1'b1;
            q_req_o.waddr = tail_q;
            q_req_o.wdata = idx_q;
            tail_d        = tail_q + IDX_W'(1);
            count_d       = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      fresh_q   <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      fresh_q   <= fresh_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_cmd_i;
      idx_q  <= s_idx_i;
      hgen_q <= s_gen_i;
    end
    if (commit) begin
      m_status_q <= res_status;
      m_idx_q    <= res_idx;
      m_gen_q    <= res_gen;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_idx_o    = m_idx_q;
  assign m_gen_o    = m_gen_q;

endmodule

>>> sv/generational_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator
// An accepted transaction reads the generation memory, then its result is
// registered; an allocation served from the free queue reads the queue first.
// One transaction is in flight at a time, held by the read-modify-write of the
// generation memory and by a stalled result. After reset a clearing pass zeroes
// the generation memory; no transaction is accepted until it completes.
// ----------------------------------------------------------------------------
module generational_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: slot_index[9:0], handle_generation[25:10], zero pad.
  input  logic [31:0] s_axis_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: result_index[9:0], result_generation[25:10], zero pad.
  output logic [31:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [1:0]  m_axis_tuser
);
  import gsa_pkg::*;

  gsa_cfg_t     cfg;
  gsa_gen_req_t gen_req;
  gsa_q_req_t   q_req;
  logic [GEN_W-1:0] gen_rdata;
  logic [IDX_W-1:0] q_rdata;
  logic [IDX_W-1:0] m_idx;
  logic [GEN_W-1:0] m_gen;

  gsa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gsa_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_req.we),
    .waddr_i (gen_req.waddr),
    .wdata_i (gen_req.wdata),
    .re_i    (gen_req.re),
    .raddr_i (gen_req.raddr),
    .rdata_o (gen_rdata)
  );

  gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_req.we),
    .waddr_i (q_req.waddr),
    .wdata_i (q_req.wdata),
    .re_i    (q_req.re),
    .raddr_i (q_req.raddr),
    .rdata_o (q_rdata)
  );

  gsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_cmd_i     (s_axis_tuser),
    .s_idx_i     (s_axis_tdata[IDX_W-1:0]),
    .s_gen_i     (s_axis_tdata[IDX_W+GEN_W-1:IDX_W]),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_status_o  (m_axis_tuser),
    .m_idx_o     (m_idx),
    .m_gen_o     (m_gen),
    .gen_req_o   (gen_req),
    .gen_rdata_i (gen_rdata),
    .q_req_o     (q_req),
    .q_rdata_i   (q_rdata)
  );

  assign m_axis_tdata = {{(32-IDX_W-GEN_W){1'b0}}, m_gen, m_idx};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("transaction accepted while the previous one is in flight");

  a_gen_rw_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gen_req.we && gen_req.re))
    else $error("generation memory read and written in the same cycle");

  a_no_accept_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !gen_req.we && !q_req.we)
    else $error("transaction accepted during a memory write-back");

endmodule

>>> tb/sv/generational_slot_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator testbench
// Drives allocate, release and lookup requests into the request stream. A
// scoreboard mirrors the generation table, the released-slot queue and the
// fresh-slot counter, and predicts each response. Every response is checked
// field by field against the oldest prediction. Directed tests cover
// exhaustion, out-of-range indices, stale handles, the unused command, a
// slot count of zero, a lowered slot count and an oversized slot count.
// Random traffic then runs under several slot counts and stall patterns, and
// a final test releases one slot many times in a row so that it is queued
// again and again.
// ----------------------------------------------------------------------------
module generational_slot_allocator_test;
  import gsa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] SLOT_COUNT_ADDR = 3'd0;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    index;
    logic [GEN_W-1:0]    generation;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic [GEN_W-1:0] gen_table [SLOTS];
  logic [IDX_W-1:0] released_slots [$];
  logic [CNT_W-1:0] fresh_next_q;
  logic [CNT_W-1:0] slot_count_q;
  alloc_result_t    pending_results [$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          error_count = 0;
  int unsigned cycle_count = 0;

  generational_slot_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    alloc_result_t want;
    alloc_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = m_axis_tuser;
      got.index      = m_axis_tdata[IDX_W-1:0];
      got.generation = m_axis_tdata[IDX_W +: GEN_W];
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected response, status %0d index %0d generation %0d",
                 $time, got.status, got.index, got.generation);
      end else begin
        want = pending_results.pop_front();
        if (want != got) begin
          error_count++;
          if (want.status != got.status)
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
          if (want.index != got.index)
            $display("%0t: index mismatch, expected %0d, actual %0d",
                     $time, want.index, got.index);
          if (want.generation != got.generation)
            $display("%0t: generation mismatch, expected %0d, actual %0d",
                     $time, want.generation, got.generation);
        end
      end
    end
  end

  function automatic logic [CNT_W-1:0] active_limit();
    return (slot_count_q > SLOTS_CNT) ? SLOTS_CNT : slot_count_q;
  endfunction

  function automatic alloc_result_t predict_result(input logic [CMD_W-1:0] cmd,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [GEN_W-1:0] hgen);
    alloc_result_t    res;
    logic [CNT_W-1:0] lim;
    logic [GEN_W-1:0] cur;
    res = '{status: STATUS_OK, index: '0, generation: '0};
    lim = active_limit();
    if (cmd == CMD_ALLOC) begin
      if (fresh_next_q < lim) begin
        res.index = fresh_next_q[IDX_W-1:0];
        fresh_next_q = fresh_next_q + 1'b1;
        res.generation = gen_table[res.index];
      end else if (released_slots.size() > 0) begin
        res.index = released_slots.pop_front();
        res.generation = gen_table[res.index];
      end else begin
        res.status = STATUS_EXHAUSTED;
      end
    end else if (cmd == CMD_UNUSED) begin
      res.status = STATUS_OK;
    end else if ({1'b0, idx} >= lim) begin
      res.status = STATUS_RANGE;
    end else begin
      cur = gen_table[idx];
      res.index = idx;
      if (cur != hgen) begin
        res.status = STATUS_STALE;
      end else if (cmd == CMD_RELEASE) begin
        cur = cur + 1'b1;
        gen_table[idx] = cur;
        if (released_slots.size() < SLOTS) released_slots.push_back(idx);
      end
      res.generation = cur;
    end
    return res;
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < SLOTS; i++) gen_table[i] = '0;
    released_slots.delete();
    fresh_next_q = '0;
    slot_count_q = SLOTS_CNT;
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                              input logic [GEN_W-1:0] hgen);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, hgen, idx};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_result(cmd, idx, hgen));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [CNT_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLOT_COUNT_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    slot_count_q = value;
  endtask

  task automatic test_fresh_allocation();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) send_request(CMD_ALLOC, 10'h3FF, 16'hFFFF);
    send_request(CMD_LOOKUP, 10'd1, 16'h0000);
    send_request(CMD_LOOKUP, 10'h3FF, 16'hFFFF);
    send_request(CMD_UNUSED, 10'h3FF, 16'hFFFF);
    send_request(CMD_RELEASE, 10'd1, 16'h0000);
    send_request(CMD_RELEASE, 10'd1, 16'h0000);
    send_request(CMD_LOOKUP, 10'd1, 16'h0001);
    send_request(CMD_RELEASE, 10'h3FF, 16'h0000);
  endtask

  task automatic test_exhaustion_and_range();
    write_slot_count(11'd2);
    repeat (3) send_request(CMD_ALLOC, 10'd0, 16'h0000);
    send_request(CMD_RELEASE, 10'd2, 16'h0000);
    send_request(CMD_LOOKUP, 10'h3FF, 16'h0000);
    send_request(CMD_RELEASE, 10'd0, 16'h0000);
    send_request(CMD_ALLOC, 10'd0, 16'h0000);
    send_request(CMD_RELEASE, 10'd0, 16'h0001);
  endtask

  task automatic test_zero_count();
    write_slot_count(11'd0);
    send_request(CMD_ALLOC, 10'd0, 16'h0000);
    send_request(CMD_ALLOC, 10'd0, 16'h0000);
    send_request(CMD_LOOKUP, 10'd0, 16'h0002);
    send_request(CMD_RELEASE, 10'd0, 16'h0002);
  endtask

  task automatic test_oversized_count();
    write_slot_count(11'h7FF);
    send_request(CMD_LOOKUP, 10'h3FF, 16'h0000);
    send_request(CMD_ALLOC, 10'd0, 16'h0000);
    send_request(CMD_RELEASE, 10'h3FF, 16'h0000);
  endtask

  task automatic test_random_traffic(input logic [CNT_W-1:0] count, input int idle_pct,
                                     input int stall_pct, input int items);
    int unsigned      pick;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] lim;
    write_slot_count(count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) drain_results();
      lim  = active_limit();
      pick = $urandom_range(99);
      idx  = IDX_W'($urandom);
      gen  = GEN_W'($urandom);
      cmd  = $urandom_range(1) ? CMD_RELEASE : CMD_LOOKUP;
      if (pick < 35) begin
        cmd = CMD_ALLOC;
      end else if (pick < 75) begin
        if (lim != 0) idx = IDX_W'($urandom_range(lim - 1));
        gen = gen_table[idx];
      end else if (pick < 85) begin
        gen = gen_table[idx];
      end else if (pick >= 94) begin
        cmd = CMD_UNUSED;
      end
      send_request(cmd, idx, gen);
    end
  endtask

  task automatic test_repeated_release();
    write_slot_count(11'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) send_request(CMD_RELEASE, 10'd0, gen_table[0]);
    send_request(CMD_LOOKUP, 10'd0, gen_table[0]);
    repeat (4) send_request(CMD_ALLOC, 10'd0, 16'h0000);
  endtask

  initial begin
    reset_predictor();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fresh_allocation();
    test_exhaustion_and_range();
    test_zero_count();
    test_oversized_count();
    test_random_traffic(SLOTS_CNT, 0, 0, 110);
    test_random_traffic(CNT_W'($urandom_range(1, 16)), 65, 0, 110);
    test_random_traffic(CNT_W'($urandom_range(1, 1024)), 0, 65, 110);
    test_random_traffic(CNT_W'($urandom_range(0, 2047)), 34, 34, 110);
    test_repeated_release();
    drain_results();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
